/* design/sla_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and constants of the segment list allocator.
// ----------------------------------------------------------------------------
package sla_pkg;
   localparam int MaxSegments = 64;
   localparam int AddrWidth   = 32;
   localparam int IdxWidth    = $clog2(MaxSegments + 1);
   localparam int SlotWidth   = $clog2(MaxSegments);
   localparam logic [IdxWidth-1:0] Nil = IdxWidth'(MaxSegments);

   localparam logic [2:0] StOk      = 3'd0;
   localparam logic [2:0] StZero    = 3'd1;
   localparam logic [2:0] StNoSpace = 3'd2;
   localparam logic [2:0] StUnknown = 3'd3;
   localparam logic [2:0] StDouble  = 3'd4;

   localparam logic KindAlloc = 1'b0;
   localparam logic KindFree  = 1'b1;

   localparam logic [1:0] CsrFitPolicy   = 2'd0;
   localparam logic [1:0] CsrHeaderBytes = 2'd1;
   localparam logic [1:0] CsrHeapLimit   = 2'd2;

   typedef struct packed {
      logic [AddrWidth-1:0] start;
      logic [AddrWidth-1:0] length;
      logic [IdxWidth-1:0]  following;
      logic [IdxWidth-1:0]  preceding;
   } seg_entry_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [AddrWidth-1:0] data_address;
      logic [AddrWidth-1:0] free_total;
      logic [AddrWidth-1:0] segment_total;
      logic [AddrWidth-1:0] longest_free;
   } rsp_type;

   typedef struct packed {
      logic                 kind;
      logic [AddrWidth-1:0] request_size;
      logic [AddrWidth-1:0] block_address;
   } req_type;
endpackage

/* design/sla_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_req_if / sla_rsp_if
// Valid/ready channels carrying requests and responses.
// ----------------------------------------------------------------------------
interface sla_req_if import sla_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sla_rsp_if import sla_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* design/sla_seg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_seg_ram
// Segment table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sla_seg_ram import sla_pkg::*; (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [SlotWidth-1:0] wr_addr,
   input  seg_entry_type        wr_data,
   input  logic [SlotWidth-1:0] rd_addr,
   output seg_entry_type        rd_data
);
   seg_entry_type mem [MaxSegments];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* design/segment_list_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_list_allocator
// Address-ordered segment heap with first/best fit and, under first fit, merge on free.
// ----------------------------------------------------------------------------
// One request is handled at a time. Each request walks the segment list in
// the table memory up to twice, one entry at a time (read issue, read data):
// a search pass, the table updates and a second pass that finds the largest
// free segment; a zero-size allocation skips the search. A new request is
// taken while the last response still waits in the output register. Free
// and in-use flags live in flops.
module segment_list_allocator import sla_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sla_req_if.sink     req,
   sla_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_ALLOC_NEW, S_FREE_NB,
      S_NB_RD, S_NB_CHK, S_MERGE, S_FIX_AFTER, S_LG_RD, S_LG_CHK, S_DONE
   } state_type;

   state_type            state_ff;
   logic                 policy_ff;
   logic [7:0]           hdr_ff;
   logic [31:0]          limit_ff;
   logic [MaxSegments-1:0] is_free_ff, in_use_ff;
   logic [IdxWidth-1:0]  head_ff, tail_ff;
   logic [31:0]          brk_ff, free_ff, grown_ff;
   req_type              cur_ff;
   logic [IdxWidth-1:0]  ptr_ff, best_ff, first_ff, last_ff, after_ff;
   logic [31:0]          best_left_ff, largest_ff, addr_ff;
   logic [2:0]           status_ff;
   logic [6:0]           guard_ff;
   seg_entry_type        p_ent_ff, prv_ent_ff, nxt_ent_ff;
   logic                 nb_sel_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   logic [IdxWidth-1:0]  p_ent_ff_slot_ff;

   logic                 wr_en;
   logic [SlotWidth-1:0] wr_addr, rd_addr;
   seg_entry_type        wr_data, rd_data;

   sla_seg_ram u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   // lowest unused slot
   logic [IdxWidth-1:0] free_slot;
   always_comb begin
      free_slot = Nil;
      for (int i = MaxSegments - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) free_slot = IdxWidth'(i);
      end
   end

   logic [SlotWidth-1:0] ptr_s;
   assign ptr_s = ptr_ff[SlotWidth-1:0];
   logic [32:0] left_w, new_end;
   assign left_w  = {1'b0, rd_data.length} - {1'b0, cur_ff.request_size};
   assign new_end = {1'b0, brk_ff} + 33'(hdr_ff) + {1'b0, cur_ff.request_size};
   logic [31:0] merged_w;
   assign merged_w = nxt_ent_ff.start + nxt_ent_ff.length;

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // slot of the freed segment: equals last_ff when no following merge
   function automatic logic [IdxWidth-1:0] cur_ff_slot();
      return (first_ff == p_ent_ff.preceding) ? p_ent_ff_slot_ff : first_ff;
   endfunction

   always_ff @(posedge clock) begin
      if (state_ff == S_SRCH_CHK && cur_ff.kind == KindFree) p_ent_ff_slot_ff <= ptr_ff;
   end

   // memory port usage
   always_comb begin
      rd_addr = ptr_s;
      wr_en   = 1'b0;
      wr_addr = ptr_s;
      wr_data = p_ent_ff;
      unique case (state_ff)
         S_SRCH_RD: begin
            // end of walk: fetch the best candidate
            if ((ptr_ff == Nil || guard_ff == 7'(MaxSegments)) && best_ff != Nil) begin
               rd_addr = best_ff[SlotWidth-1:0];
            end
         end
         S_ALLOC_NEW: begin
            if (!(new_end > {1'b0, limit_ff}) && free_slot != Nil) begin
               wr_en   = 1'b1;
               wr_addr = free_slot[SlotWidth-1:0];
               wr_data.start     = new_end[31:0] - cur_ff.request_size;
               wr_data.length    = cur_ff.request_size;
               wr_data.following = Nil;
               wr_data.preceding = tail_ff;
            end
         end
         S_FIX_AFTER: begin
            wr_en = 1'b1;
            wr_addr = tail_ff[SlotWidth-1:0];
            wr_data = prv_ent_ff;
            wr_data.following = after_ff;
         end
         S_MERGE: begin
            wr_en   = 1'b1;
            wr_addr = first_ff[SlotWidth-1:0];
            wr_data = prv_ent_ff;
            wr_data.length    = merged_w - prv_ent_ff.start;
            wr_data.following = after_ff;
         end
         S_NB_CHK: begin
            // patch preceding of segment after the merge
            if (nb_sel_ff) begin
               wr_en   = 1'b1;
               wr_addr = ptr_s;
               wr_data = rd_data;
               wr_data.preceding = first_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= 1'b0;
         hdr_ff       <= 8'd40;
         limit_ff     <= 32'hFFFF_FFFF;
         is_free_ff   <= '0;
         in_use_ff    <= '0;
         head_ff      <= Nil;
         tail_ff      <= Nil;
         brk_ff       <= '0;
         free_ff      <= '0;
         grown_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CsrFitPolicy:   policy_ff <= csr_wr_data[0];
               CsrHeaderBytes: hdr_ff    <= csr_wr_data[7:0];
               CsrHeapLimit:   limit_ff  <= csr_wr_data;
               default: ;
            endcase
         end
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  cur_ff    <= req.payload;
                  ptr_ff    <= head_ff;
                  best_ff   <= Nil;
                  guard_ff  <= '0;
                  addr_ff   <= '0;
                  if (req.payload.kind == KindAlloc && req.payload.request_size == '0) begin
                     status_ff  <= StZero;
                     largest_ff <= '0;
                     state_ff   <= S_LG_RD;
                  end else begin
                     status_ff <= StOk;
                     state_ff  <= S_SRCH_RD;
                  end
               end
            end
            S_SRCH_RD: begin
               if (ptr_ff == Nil || guard_ff == 7'(MaxSegments)) begin
                  if (cur_ff.kind == KindFree) begin
                     status_ff <= StUnknown;
                     ptr_ff <= head_ff; largest_ff <= '0;
                     state_ff <= S_LG_RD;
                  end else if (best_ff != Nil) begin
                     ptr_ff <= best_ff;
                     state_ff <= S_SRCH_CHK;
                     guard_ff <= 7'(MaxSegments) + 7'd1;
                  end else begin
                     state_ff <= S_ALLOC_NEW;
                  end
               end else begin
                  guard_ff <= guard_ff + 7'd1;
                  state_ff <= S_SRCH_CHK;
               end
            end
            S_SRCH_CHK: begin
               if (guard_ff == 7'(MaxSegments) + 7'd1) begin
                  // re-read of chosen best fit: take it
                  is_free_ff[ptr_s] <= 1'b0;
                  free_ff  <= free_ff - rd_data.length;
                  addr_ff  <= rd_data.start;
                  ptr_ff <= head_ff; largest_ff <= '0;
                  state_ff <= S_LG_RD;
               end else if (cur_ff.kind == KindAlloc) begin
                  if (is_free_ff[ptr_s] && !left_w[32] &&
                      (!policy_ff || left_w[31:0] == '0)) begin
                     is_free_ff[ptr_s] <= 1'b0;
                     free_ff  <= free_ff - rd_data.length;
                     addr_ff  <= rd_data.start;
                     ptr_ff <= head_ff; largest_ff <= '0;
                     state_ff <= S_LG_RD;
                  end else begin
                     if (is_free_ff[ptr_s] && !left_w[32] &&
                         (best_ff == Nil || left_w[31:0] < best_left_ff)) begin
                        best_ff <= ptr_ff;
                        best_left_ff <= left_w[31:0];
                     end
                     ptr_ff   <= rd_data.following;
                     state_ff <= S_SRCH_RD;
                  end
               end else begin
                  if (rd_data.start == cur_ff.block_address) begin
                     p_ent_ff <= rd_data;
                     if (is_free_ff[ptr_s]) begin
                        status_ff <= StDouble;
                        ptr_ff <= head_ff; largest_ff <= '0;
                        state_ff <= S_LG_RD;
                     end else begin
                        is_free_ff[ptr_s] <= 1'b1;
                        free_ff  <= free_ff + rd_data.length;
                        first_ff <= ptr_ff;
                        last_ff  <= ptr_ff;
                        if (policy_ff) begin
                           ptr_ff <= head_ff; largest_ff <= '0;
                           state_ff <= S_LG_RD;
                        end else begin
                           state_ff <= S_FREE_NB;
                        end
                     end
                  end else begin
                     ptr_ff   <= rd_data.following;
                     state_ff <= S_SRCH_RD;
                  end
               end
            end
            S_ALLOC_NEW: begin
               if (new_end > {1'b0, limit_ff} || free_slot == Nil) begin
                  status_ff <= StNoSpace;
                  ptr_ff <= head_ff; largest_ff <= '0;
                  state_ff <= S_LG_RD;
               end else begin
                  in_use_ff[free_slot[SlotWidth-1:0]]  <= 1'b1;
                  is_free_ff[free_slot[SlotWidth-1:0]] <= 1'b0;
                  brk_ff   <= new_end[31:0];
                  grown_ff <= grown_ff + cur_ff.request_size;
                  addr_ff  <= new_end[31:0] - cur_ff.request_size;
                  if (tail_ff == Nil) begin
                     head_ff <= free_slot;
                     tail_ff <= free_slot;
                     ptr_ff <= free_slot; largest_ff <= '0;
                     state_ff <= S_LG_RD;
                  end else begin
                     // fetch old tail to link it; hold the new slot
                     ptr_ff   <= tail_ff;
                     after_ff <= free_slot;
                     nb_sel_ff <= 1'b0;
                     state_ff <= S_NB_RD;
                     first_ff <= Nil;
                  end
               end
            end
            S_FREE_NB: begin
               // read preceding neighbor first, then following
               nb_sel_ff <= 1'b0;
               if (p_ent_ff.preceding == Nil ||
                   !is_free_ff[p_ent_ff.preceding[SlotWidth-1:0]]) begin
                  first_ff <= last_ff;
                  prv_ent_ff <= p_ent_ff;
                  nxt_ent_ff <= p_ent_ff;
                  after_ff  <= p_ent_ff.following;
                  if (p_ent_ff.following == Nil ||
                      !is_free_ff[p_ent_ff.following[SlotWidth-1:0]]) begin
                     ptr_ff <= head_ff; largest_ff <= '0;
                     state_ff <= S_LG_RD;
                  end else begin
                     ptr_ff  <= p_ent_ff.following;
                     last_ff <= p_ent_ff.following;
                     guard_ff <= 7'd1;
                     state_ff <= S_NB_RD;
                  end
               end else begin
                  first_ff <= p_ent_ff.preceding;
                  ptr_ff   <= p_ent_ff.preceding;
                  state_ff <= S_NB_RD;
                  nxt_ent_ff <= p_ent_ff;
                  after_ff <= p_ent_ff.following;
                  guard_ff <= 7'd0;
               end
            end
            S_NB_RD: state_ff <= S_NB_CHK;
            S_NB_CHK: begin
               if (first_ff == Nil && cur_ff.kind == KindAlloc) begin
                  prv_ent_ff <= rd_data;
                  state_ff <= S_FIX_AFTER;
               end else if (nb_sel_ff) begin
                  ptr_ff <= head_ff; largest_ff <= '0;
                  state_ff <= S_LG_RD;
               end else if (guard_ff == 7'd0) begin
                  // preceding neighbor read; now maybe following
                  prv_ent_ff <= rd_data;
                  in_use_ff[last_ff[SlotWidth-1:0]]  <= 1'b0;
                  is_free_ff[last_ff[SlotWidth-1:0]] <= 1'b0;
                  if (p_ent_ff.following != Nil &&
                      is_free_ff[p_ent_ff.following[SlotWidth-1:0]]) begin
                     ptr_ff  <= p_ent_ff.following;
                     last_ff <= p_ent_ff.following;
                     guard_ff <= 7'd1;
                     state_ff <= S_NB_RD;
                  end else begin
                     state_ff <= S_MERGE;
                  end
               end else begin
                  // following neighbor read and absorbed
                  nxt_ent_ff <= rd_data;
                  after_ff   <= rd_data.following;
                  in_use_ff[ptr_s]  <= 1'b0;
                  is_free_ff[ptr_s] <= 1'b0;
                  state_ff <= S_MERGE;
               end
            end
            S_MERGE: begin
               free_ff <= free_ff + (merged_w - prv_ent_ff.start) -
                          (first_ff == p_ent_ff.preceding ? prv_ent_ff.length : 32'd0) -
                          p_ent_ff.length -
                          (last_ff != cur_ff_slot() ? nxt_ent_ff.length : 32'd0);
               if (after_ff == Nil) begin
                  tail_ff <= first_ff;
                  ptr_ff <= head_ff; largest_ff <= '0;
                  state_ff <= S_LG_RD;
               end else begin
                  ptr_ff <= after_ff;
                  nb_sel_ff <= 1'b1;
                  state_ff <= S_NB_RD;
               end
            end
            S_FIX_AFTER: begin
               tail_ff <= after_ff;
               ptr_ff <= head_ff; largest_ff <= '0;
               state_ff <= S_LG_RD;
            end
            S_LG_RD: begin
               if (ptr_ff == Nil) state_ff <= S_DONE;
               else state_ff <= S_LG_CHK;
            end
            S_LG_CHK: begin
               if (is_free_ff[ptr_s] && rd_data.length > largest_ff)
                  largest_ff <= rd_data.length;
               ptr_ff   <= rd_data.following;
               state_ff <= S_LG_RD;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_ff.status        <= status_ff;
                  rsp_ff.data_address  <= (status_ff == StOk && cur_ff.kind == KindAlloc)
                                          ? addr_ff : '0;
                  rsp_ff.free_total    <= free_ff;
                  rsp_ff.segment_total <= grown_ff;
                  rsp_ff.longest_free  <= largest_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_tail_nil_head: assert property (@(posedge clock) disable iff (reset)
      (tail_ff == Nil) |-> (head_ff == Nil))
      else $error("tail empty while head set");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("response dropped");
   a_free_subset: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> ((is_free_ff & ~in_use_ff) == '0))
      else $error("free flag on unused slot");
`endif
endmodule
